>>> hw/rtl/fds_pkg.sv
// Shared types and constants for the Forth data stack unit.
// Depends on nothing; fds_ctrl and the top level import it.
package fds_pkg;

	localparam int REQ_W    = 3;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int DEPTH_W  = 9;

	typedef enum logic [REQ_W-1:0] {
		OP_PUSH = 3'd0,
		OP_POP  = 3'd1,
		OP_DUP  = 3'd2,
		OP_SWAP = 3'd3,
		OP_OVER = 3'd4,
		OP_DROP = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_LOAD
	} state_t;

	// One finished result, handed from the sequencer to the output register.
	typedef struct packed {
		logic                vld;
		status_t             status;
		logic [VAL_W-1:0]    value;
		logic [DEPTH_W-1:0]  depth;
	} rsp_t;

endpackage

>>> hw/rtl/fds_mem.sv
// Single-port synchronous entry memory of the Forth data stack unit.
// One read or one write per cycle, read data registered. No dependencies.
module fds_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/fds_ctrl.sv
// Request sequencer of the Forth data stack unit: holds the top entry and the
// entry count in registers and drives the entry memory. Depends on fds_pkg.
module fds_ctrl #(
	parameter int STACK_DEPTH  = 256,
	parameter int HANDLE_WIDTH = 32,
	localparam int AW = $clog2(STACK_DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [fds_pkg::REQ_W-1:0]    req_type,
	input  logic [fds_pkg::VAL_W-1:0]    push_value,
	input  logic                         slot_free,
	output logic                         mem_en,
	output logic                         mem_we,
	output logic [AW-1:0]                mem_addr,
	output logic [HANDLE_WIDTH-1:0]      mem_wdata,
	input  logic [HANDLE_WIDTH-1:0]      mem_rdata,
	output fds_pkg::rsp_t                res
);

	import fds_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t                  state_q, state_d;
	op_t                     op_q, op_in;
	logic [CW-1:0]           count_q, count_d;
	logic [HANDLE_WIDTH-1:0] tos_q, tos_d;
	logic [CW-1:0]           cnt_m1, cnt_m2, cnt_p1;
	logic [1:0]              need;
	logic                    grows, known, under, full, ok, fire, needs_load;

	assign op_in  = op_t'(req_type);
	assign fire   = req_valid && req_ready;
	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);
	assign cnt_p1 = count_q + CW'(1);

	// Entry requirements of each request.
	always_comb begin
		need  = 2'd0;
		grows = 1'b0;
		known = 1'b1;
		case (op_in)
			OP_PUSH: grows = 1'b1;
			OP_POP, OP_DROP: need = 2'd1;
			OP_DUP: begin
				need  = 2'd1;
				grows = 1'b1;
			end
			OP_SWAP: need = 2'd2;
			OP_OVER: begin
				need  = 2'd2;
				grows = 1'b1;
			end
			default: known = 1'b0;
		endcase
		under = known && (count_q < CW'(need));
		full  = known && grows && (count_q == CW'(STACK_DEPTH));
		ok    = known && !under && !full;
		needs_load = ok && ((op_in == OP_SWAP) || (op_in == OP_OVER) ||
			(((op_in == OP_POP) || (op_in == OP_DROP)) && (count_q >= CW'(2))));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (fire && needs_load) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs and datapath updates.
	always_comb begin
		req_ready  = (state_q == S_IDLE) && slot_free;
		mem_en     = 1'b0;
		mem_we     = 1'b0;
		mem_addr   = cnt_m1[AW-1:0];
		mem_wdata  = tos_q;
		count_d    = count_q;
		tos_d      = tos_q;
		res.vld    = 1'b0;
		res.status = ST_OK;
		res.value  = '0;
		res.depth  = DEPTH_W'(count_q);
		case (state_q)
			S_IDLE: begin
				if (fire) begin
					res.vld = 1'b1;
					if (under) begin
						res.status = ST_UNDER;
					end else if (full) begin
						res.status = ST_OVER;
					end else begin
						case (op_in)
							OP_PUSH: begin
								mem_en    = (count_q != '0);
								mem_we    = 1'b1;
								tos_d     = HANDLE_WIDTH'(push_value);
								count_d   = cnt_p1;
								res.depth = DEPTH_W'(cnt_p1);
							end
							OP_POP, OP_DROP: begin
								// The entry below becomes the new top in the load cycle.
								mem_en    = (count_q >= CW'(2));
								mem_addr  = cnt_m2[AW-1:0];
								count_d   = cnt_m1;
								res.value = VAL_W'(tos_q);
								res.depth = DEPTH_W'(cnt_m1);
							end
							OP_DUP: begin
								mem_en    = 1'b1;
								mem_we    = 1'b1;
								count_d   = cnt_p1;
								res.value = VAL_W'(tos_q);
								res.depth = DEPTH_W'(cnt_p1);
							end
							OP_SWAP, OP_OVER: begin
								mem_en   = 1'b1;
								mem_addr = cnt_m2[AW-1:0];
								res.vld  = 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
			end
			S_LOAD: begin
				tos_d = mem_rdata;
				case (op_q)
					OP_SWAP: begin
						mem_en   = 1'b1;
						mem_we   = 1'b1;
						mem_addr = cnt_m2[AW-1:0];
						res.vld  = 1'b1;
					end
					OP_OVER: begin
						mem_en    = 1'b1;
						mem_we    = 1'b1;
						count_d   = cnt_p1;
						res.vld   = 1'b1;
						res.value = VAL_W'(mem_rdata);
						res.depth = DEPTH_W'(cnt_p1);
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		tos_q <= tos_d;
		if (fire) begin
			op_q <= op_in;
		end
	end

endmodule

>>> hw/rtl/forth_data_stack_unit_top.sv
// Top level of the Forth data stack unit: request sequencer, entry memory and
// result output register. Depends on fds_pkg, fds_ctrl and fds_mem.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   request  | req_valid, req_ready | req_type, push_value
//   response | rsp_valid, rsp_ready | status, out_value, depth_after
//
// Push, dup, every error and an unknown request end in the idle state; pop
// and drop pass through the load state while entries remain below the removed
// top, swap and over whenever they succeed. As the memory has a single port,
// the entry below the top is read as the request is taken and becomes the
// new top in the load state, where swap and over also write the old top.
// Reset clears the entry count and the sequencer; the memory is not cleared
// and needs no clearing pass, since only entries below the count are read.
// A request beat is taken only while the sequencer is idle and the output
// register is empty or being emptied in the same cycle.
module forth_data_stack_unit_top #(
	parameter int STACK_DEPTH  = 256,
	parameter int HANDLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [fds_pkg::REQ_W-1:0]      req_type,
	input  logic [fds_pkg::VAL_W-1:0]      push_value,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [fds_pkg::STATUS_W-1:0]   status,
	output logic [fds_pkg::VAL_W-1:0]      out_value,
	output logic [fds_pkg::DEPTH_W-1:0]    depth_after
);

	import fds_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);

	rsp_t                    res;
	logic                    slot_free;
	logic                    mem_en, mem_we;
	logic [AW-1:0]           mem_addr;
	logic [HANDLE_WIDTH-1:0] mem_wdata, mem_rdata;

	logic                    rsp_valid_q;
	status_t                 status_q;
	logic [VAL_W-1:0]        value_q;
	logic [DEPTH_W-1:0]      depth_q;

	// The output register may take a new result when it is empty or its
	// current beat leaves in this cycle.
	assign slot_free = !rsp_valid_q || rsp_ready;

	fds_ctrl #(
		.STACK_DEPTH  (STACK_DEPTH),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_type   (req_type),
		.push_value (push_value),
		.slot_free  (slot_free),
		.mem_en     (mem_en),
		.mem_we     (mem_we),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata),
		.res        (res)
	);

	fds_mem #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (HANDLE_WIDTH)
	) u_mem (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Output register: holds a result beat until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res.vld) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			status_q <= res.status;
			value_q  <= res.value;
			depth_q  <= res.depth;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign out_value   = value_q;
	assign depth_after = depth_q;

	// A result never overwrites a beat that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.vld |-> (!rsp_valid_q || rsp_ready))
		else $error("result written over a pending response beat");

	// Errors carry no handle.
	a_err_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status != ST_OK)) |-> (out_value == '0))
		else $error("error response carries a handle");

	// Overflow is reported only on a full stack.
	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == ST_OVER)) |-> (depth_after == DEPTH_W'(STACK_DEPTH)))
		else $error("overflow reported on a stack that is not full");

	// Underflow is reported only with fewer than two entries.
	a_under_low: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == ST_UNDER)) |-> (depth_after <= DEPTH_W'(1)))
		else $error("underflow reported with enough entries");

endmodule
